### rtl/diffusion_stencil_2d_core_assert.svh
// Assertion macros for the diffusion stencil core.
// Included by the top level; depends on nothing else.
`ifndef DIFFUSION_STENCIL_2D_CORE_ASSERT_SVH
`define DIFFUSION_STENCIL_2D_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DST2D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("diffusion_stencil_2d_core: check failed");

// The consequent must hold in the cycle after the antecedent.
`define DST2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("diffusion_stencil_2d_core: check failed");

`endif

### rtl/dst2d_pkg.sv
// Shared types and constants for the diffusion stencil core.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dst2d_pkg;

    localparam int SAMPLE_W       = 20;
    localparam int CFG_W          = 9;
    localparam int GAIN_W         = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int MIN_SIZE       = 3;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [CFG_W-1:0]  RST_GRID_SIZE = 9'd251;
    localparam logic [GAIN_W-1:0] RST_GAIN      = 16'd16384;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;
    localparam int INFLIGHT_W  = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = sample_t'((2 ** (SAMPLE_W - 1)) - 1);
    localparam sample_t SAMPLE_MIN = sample_t'(-(2 ** (SAMPLE_W - 1)));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_GAIN_X      = 2'd2,
        REG_GAIN_Y      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_x;
        logic [GAIN_W-1:0] gain_y;
    } gains_t;

    typedef struct packed {
        logic push;
        logic last;
    } res_ctl_t;

    typedef struct packed {
        sample_t u;
        sample_t v;
        logic    last;
    } fifo_entry_t;

endpackage

`default_nettype wire

### rtl/dst2d_seq.sv
// Raster sequencer: configuration registers, column and row counters and the
// control pipeline that travels beside the lanes. Depends on dst2d_pkg.
`default_nettype none

module dst2d_seq
    import dst2d_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int ROW_W     = $clog2(MAX_HEIGHT)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic [COL_W-1:0]           rd_addr,
    output logic                       wr_en,
    output logic [COL_W-1:0]           wr_addr,
    output gains_t                     gains,
    output res_ctl_t                   res_ctl,
    output logic [INFLIGHT_W-1:0]      inflight
);

    localparam int WLIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HLIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP_W = (WLIM_W > CFG_W) ? WLIM_W : CFG_W;
    localparam int HCMP_W = (HLIM_W > CFG_W) ? HLIM_W : CFG_W;

    logic [CFG_W-1:0]  grid_width_reg;
    logic [CFG_W-1:0]  grid_height_reg;
    logic [GAIN_W-1:0] gain_x_reg;
    logic [GAIN_W-1:0] gain_y_reg;

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic [WCMP_W-1:0] width_ext;
    logic [WCMP_W-1:0] width_lim;
    logic [HCMP_W-1:0] height_ext;
    logic [HCMP_W-1:0] height_lim;
    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;
    logic              at_last_col;
    logic              at_last_row;
    logic              emit;
    logic              size_write;

    logic              v1_reg;
    logic              emit1_reg;
    logic              last1_reg;
    logic [COL_W-1:0]  col1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    logic              v5_reg;
    logic              last2_reg;
    logic              last3_reg;
    logic              last4_reg;
    logic              last5_reg;

    // Sizes outside the supported range are clamped before use.
    always_comb
    begin
        width_ext  = WCMP_W'(grid_width_reg);
        height_ext = HCMP_W'(grid_height_reg);

        if (width_ext < WCMP_W'(MIN_SIZE))
            width_lim = WCMP_W'(MIN_SIZE);
        else if (width_ext > WCMP_W'(MAX_WIDTH))
            width_lim = WCMP_W'(MAX_WIDTH);
        else
            width_lim = width_ext;

        if (height_ext < HCMP_W'(MIN_SIZE))
            height_lim = HCMP_W'(MIN_SIZE);
        else if (height_ext > HCMP_W'(MAX_HEIGHT))
            height_lim = HCMP_W'(MAX_HEIGHT);
        else
            height_lim = height_ext;

        last_col    = COL_W'(width_lim - WCMP_W'(1));
        last_row    = ROW_W'(height_lim - HCMP_W'(1));
        at_last_col = (col_reg == last_col);
        at_last_row = (row_reg == last_row);
        emit        = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        size_write  = cfg_write && ((cfg_index == REG_GRID_WIDTH) ||
                                    (cfg_index == REG_GRID_HEIGHT));
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (size_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RST_GRID_SIZE;
            grid_height_reg <= RST_GRID_SIZE;
            gain_x_reg      <= RST_GAIN;
            gain_y_reg      <= RST_GAIN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[CFG_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[CFG_W-1:0];
                REG_GAIN_X:      gain_x_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:      gain_y_reg      <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            emit1_reg <= 1'b0;
            last1_reg <= 1'b0;
            last2_reg <= 1'b0;
            last3_reg <= 1'b0;
            last4_reg <= 1'b0;
            last5_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            v1_reg    <= accept;
            emit1_reg <= emit;
            last1_reg <= at_last_col && at_last_row;
            v2_reg    <= v1_reg && emit1_reg;
            last2_reg <= last1_reg;
            v3_reg    <= v2_reg;
            last3_reg <= last2_reg;
            v4_reg    <= v3_reg;
            last4_reg <= last3_reg;
            v5_reg    <= v4_reg;
            last5_reg <= last4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        col1_reg <= col_reg;
    end

    assign rd_addr        = col_reg;
    assign wr_en          = v1_reg;
    assign wr_addr        = col1_reg;
    assign gains.gain_x   = gain_x_reg;
    assign gains.gain_y   = gain_y_reg;
    assign res_ctl.push   = v5_reg;
    assign res_ctl.last   = last5_reg;
    assign inflight       = INFLIGHT_W'($countones({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg}));

endmodule

`default_nettype wire

### rtl/dst2d_lane.sv
// One component lane: two-row line store, 3x3 window and the pipelined
// five-point update with rounding and saturation. Depends on dst2d_pkg.
`default_nettype none

module dst2d_lane
    import dst2d_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int COL_W    = $clog2(MAX_WIDTH)
)
(
    input  wire logic             clk,
    input  wire sample_t          sample,
    input  wire logic [COL_W-1:0] rd_addr,
    input  wire logic             wr_en,
    input  wire logic [COL_W-1:0] wr_addr,
    input  wire gains_t           gains,
    output sample_t               result
);

    localparam int LAP_W   = SAMPLE_W + 2;
    localparam int PROD_W  = GAIN_W + 1 + LAP_W;
    localparam int SHIFT_W = SAMPLE_W + FRAC_BITS;
    localparam int ACC_W   = ((SHIFT_W > PROD_W) ? SHIFT_W : PROD_W) + 2;
    localparam int RND_W   = ACC_W - FRAC_BITS;

    // Each entry holds the two previous rows of one column: older row on top.
    logic [2*SAMPLE_W-1:0]     line_mem [MAX_WIDTH];
    logic [2*SAMPLE_W-1:0]     line_rd_reg;
    sample_t                   s1_reg;

    sample_t                   top_reg [3];
    sample_t                   mid_reg [3];
    sample_t                   bot_reg [3];

    sample_t                   c3_reg;
    logic signed [LAP_W-1:0]   lx3_reg;
    logic signed [LAP_W-1:0]   ly3_reg;
    sample_t                   c4_reg;
    logic signed [PROD_W-1:0]  px4_reg;
    logic signed [PROD_W-1:0]  py4_reg;
    sample_t                   res5_reg;

    sample_t                   line_top;
    sample_t                   line_mid;
    logic signed [ACC_W-1:0]   acc;
    logic signed [RND_W-1:0]   rnd;
    logic [RND_W-SAMPLE_W:0]   rnd_hi;
    sample_t                   res_next;

    assign line_top = sample_t'(line_rd_reg[2*SAMPLE_W-1:SAMPLE_W]);
    assign line_mid = sample_t'(line_rd_reg[SAMPLE_W-1:0]);

    always_ff @(posedge clk)
    begin
        line_rd_reg <= line_mem[rd_addr];
        if (wr_en)
            line_mem[wr_addr] <= {line_mid, s1_reg};
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= sample;
        if (wr_en)
        begin
            top_reg[0] <= top_reg[1];
            top_reg[1] <= top_reg[2];
            top_reg[2] <= line_top;
            mid_reg[0] <= mid_reg[1];
            mid_reg[1] <= mid_reg[2];
            mid_reg[2] <= line_mid;
            bot_reg[0] <= bot_reg[1];
            bot_reg[1] <= bot_reg[2];
            bot_reg[2] <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c3_reg  <= mid_reg[1];
        lx3_reg <= LAP_W'(mid_reg[2]) + LAP_W'(mid_reg[0]) - (LAP_W'(mid_reg[1]) <<< 1);
        ly3_reg <= LAP_W'(top_reg[1]) + LAP_W'(bot_reg[1]) - (LAP_W'(mid_reg[1]) <<< 1);

        c4_reg  <= c3_reg;
        px4_reg <= $signed({1'b0, gains.gain_x}) * lx3_reg;
        py4_reg <= $signed({1'b0, gains.gain_y}) * ly3_reg;

        res5_reg <= res_next;
    end

    // Round half up by adding half an LSB before the arithmetic shift.
    always_comb
    begin
        acc = (ACC_W'(c4_reg) <<< FRAC_BITS) + ACC_W'(px4_reg) + ACC_W'(py4_reg)
            + (ACC_W'(1) <<< (FRAC_BITS - 1));
        rnd    = RND_W'(acc >>> FRAC_BITS);
        rnd_hi = rnd[RND_W-1:SAMPLE_W-1];
        if ((&rnd_hi) || !(|rnd_hi))
            res_next = rnd[SAMPLE_W-1:0];
        else if (rnd[RND_W-1])
            res_next = SAMPLE_MIN;
        else
            res_next = SAMPLE_MAX;
    end

    assign result = res5_reg;

endmodule

`default_nettype wire

### rtl/dst2d_merge.sv
// Merging stage: joins the u and v lane results and the frame flag into one
// result queue and issues credit-based stall to the input. Depends on dst2d_pkg.
`default_nettype none

module dst2d_merge
    import dst2d_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire res_ctl_t              res_ctl,
    input  wire sample_t               u_res,
    input  wire sample_t               v_res,
    input  wire logic [INFLIGHT_W-1:0] inflight,
    input  wire logic                  result_stall,
    output logic                       result_valid,
    output sample_t                    u_updated,
    output sample_t                    v_updated,
    output logic                       frame_done,
    output logic                       sample_stall,
    output logic [FIFO_CNT_W-1:0]      fill
);

    fifo_entry_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]     rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]     count_reg;
    logic [FIFO_CNT_W-1:0]     count_next;
    logic [FIFO_CNT_W:0]       occupancy;
    logic                      pop;
    fifo_entry_t               head;

    assign pop       = result_valid && !result_stall;
    assign occupancy = (FIFO_CNT_W + 1)'(count_reg) + (FIFO_CNT_W + 1)'(inflight);

    always_comb
    begin
        count_next = count_reg;
        if (res_ctl.push && !pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (!res_ctl.push && pop)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (res_ctl.push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ctl.push)
            fifo_mem[wr_ptr_reg] <= '{u: u_res, v: v_res, last: res_ctl.last};
    end

    assign head         = fifo_mem[rd_ptr_reg];
    assign result_valid = (count_reg != '0);
    assign u_updated    = head.u;
    assign v_updated    = head.v;
    assign frame_done   = head.last;
    assign sample_stall = (occupancy >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign fill         = count_reg;

endmodule

`default_nettype wire

### rtl/diffusion_stencil_2d_core.sv
// Five-point diffusion stencil for u and v, one grid point per cycle unless stalled.
// A result is offered from the result queue once the point that completes it has passed the lanes.
// Throughput: one point per cycle unless stalled; each lane's line store reads and writes one column a cycle.
// Stall rises when the 8-entry result queue plus the points in flight would fill it.
// Reset clears the counters, the pipeline and the queue and loads the register defaults.
// The line stores are not cleared; rows are written before they are read.
`default_nettype none
`include "diffusion_stencil_2d_core_assert.svh"

module diffusion_stencil_2d_core
    import dst2d_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire sample_t               u_sample,
    input  wire sample_t               v_sample,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output sample_t                    u_updated,
    output sample_t                    v_updated,
    output logic                       frame_done,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                  sample_accept;
    logic [COL_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [COL_W-1:0]      wr_addr;
    gains_t                gains;
    res_ctl_t              res_ctl;
    logic [INFLIGHT_W-1:0] inflight;
    sample_t               u_res;
    sample_t               v_res;
    logic [FIFO_CNT_W-1:0] fill;

    assign sample_accept = sample_valid && !sample_stall;

    dst2d_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (sample_accept),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .gains     (gains),
        .res_ctl   (res_ctl),
        .inflight  (inflight)
    );

    dst2d_lane #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_u (
        .clk     (clk),
        .sample  (u_sample),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .gains   (gains),
        .result  (u_res)
    );

    dst2d_lane #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_v (
        .clk     (clk),
        .sample  (v_sample),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .gains   (gains),
        .result  (v_res)
    );

    dst2d_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_ctl      (res_ctl),
        .u_res        (u_res),
        .v_res        (v_res),
        .inflight     (inflight),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .u_updated    (u_updated),
        .v_updated    (v_updated),
        .frame_done   (frame_done),
        .sample_stall (sample_stall),
        .fill         (fill)
    );

    // The credit check must keep the result queue from ever overflowing.
    `DST2D_ASSERT_SAME(a_queue_no_overflow, clk, rst_n, res_ctl.push, fill < FIFO_DEPTH)
    `DST2D_ASSERT_NEXT(a_credit_bound, clk, rst_n, sample_accept, (inflight + fill) <= FIFO_DEPTH)
    `DST2D_ASSERT_SAME(a_idle_accepts, clk, rst_n, (inflight == 0) && (fill == 0), !sample_stall)

endmodule

`default_nettype wire

### tb/diffusion_stencil_2d_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for diffusion_stencil_2d_core: raster frames of u/v points go in,
// a local five-point stencil predictor checks every interior result. Depends on dst2d_pkg.

module diffusion_stencil_2d_core_tb
    import dst2d_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_COUNT  = 1150;
    localparam int RESET_ITEMS = 2 * 251 + 8;
    localparam int WIDE_ITEMS  = 2 * DEF_MAX_WIDTH + 16;
    localparam int LINE_DEPTH  = 2 * DEF_MAX_WIDTH;

    typedef struct packed {
        sample_t u;
        sample_t v;
    } grid_point_t;

    typedef struct packed {
        sample_t u;
        sample_t v;
        logic    last;
    } point_result_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    sample_t               u_sample     = '0;
    sample_t               v_sample     = '0;
    logic                  result_stall = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  sample_stall;
    logic                  result_valid;
    sample_t               u_updated;
    sample_t               v_updated;
    logic                  frame_done;

    grid_point_t   pending_points[$];
    point_result_t expected_points[$];
    grid_point_t   next_point;
    logic          sample_taken = 1'b0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            error_count = 0;
    int            cycle_count = 0;

    // Predictor state: register mirror, raster position, line stores and 3x3 windows.
    logic [CFG_W-1:0]  width_reg  = 9'd251;
    logic [CFG_W-1:0]  height_reg = 9'd251;
    logic [GAIN_W-1:0] gain_x_reg = 16'd16384;
    logic [GAIN_W-1:0] gain_y_reg = 16'd16384;
    int                col_pos = 0;
    int                row_pos = 0;
    sample_t           line_mem [0:1][0:LINE_DEPTH-1];
    sample_t           grid_window [0:1][0:2][0:2];

    diffusion_stencil_2d_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .u_sample     (u_sample),
        .v_sample     (v_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .u_updated    (u_updated),
        .v_updated    (v_updated),
        .frame_done   (frame_done),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int size_used(input logic [CFG_W-1:0] v, input int hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic sample_t diffuse(input sample_t c, input sample_t e, input sample_t w,
                                        input sample_t n, input sample_t s);
        longint lx;
        longint ly;
        longint acc;
        longint q;
        lx  = longint'(e) + longint'(w) - 2 * longint'(c);
        ly  = longint'(n) + longint'(s) - 2 * longint'(c);
        acc = longint'(c) * (longint'(1) << DEF_FRAC_BITS)
            + longint'(gain_x_reg) * lx + longint'(gain_y_reg) * ly;
        q   = (acc + (longint'(1) << (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
        if (q > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (q < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return sample_t'(q);
    endfunction

    function automatic sample_t pick_sample(input int style);
        case (style)
            0: return sample_t'($urandom);
            1: return sample_t'(61440 + $urandom_range(0, 8191));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return sample_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size_data();
        logic [CFG_DATA_W-1:0] d;
        if ($urandom_range(0, 9) == 0)
            d = CFG_DATA_W'($urandom_range(0, MIN_SIZE - 1));
        else
            d = CFG_DATA_W'($urandom_range(MIN_SIZE, 12));
        if ($urandom_range(0, 3) == 0)
            d[CFG_DATA_W-1:CFG_W] = 7'($urandom);
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'd65535;
            3: return CFG_DATA_W'($urandom_range(32769, 65535));
            default: return CFG_DATA_W'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 100)
            $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:
            begin
                width_reg = data[CFG_W-1:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            REG_GRID_HEIGHT:
            begin
                height_reg = data[CFG_W-1:0];
                col_pos    = 0;
                row_pos    = 0;
            end
            REG_GAIN_X: gain_x_reg = data;
            REG_GAIN_Y: gain_y_reg = data;
            default: ;
        endcase
    endtask

    task automatic queue_point(input sample_t u, input sample_t v);
        grid_point_t p;
        p.u = u;
        p.v = v;
        pending_points.push_back(p);
    endtask

    task automatic queue_frame_items(input int count, input int style);
        for (int i = 0; i < count; i++)
            queue_point(pick_sample(style), pick_sample(style));
    endtask

    // Sampled at the rising edge, where the sender side is settled.
    task automatic wait_idle();
        while (pending_points.size() != 0 || sample_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!sample_valid || sample_taken)
        begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_point = pending_points.pop_front();
                sample_valid <= 1'b1;
                u_sample     <= next_point.u;
                v_sample     <= next_point.v;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        result_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin : monitor_blk
        int            wd;
        int            ht;
        int            col;
        int            row;
        sample_t       top;
        sample_t       mid;
        sample_t       fresh [0:1];
        point_result_t want;
        point_result_t res;
        sample_taken <= sample_valid && !sample_stall;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_points.size() == 0)
                    report_mismatch($sformatf("result with none expected: u %0d v %0d",
                                              u_updated, v_updated));
                else
                begin
                    want = expected_points.pop_front();
                    if (u_updated !== want.u)
                        report_mismatch($sformatf("u_updated got %0d expected %0d",
                                                  u_updated, want.u));
                    if (v_updated !== want.v)
                        report_mismatch($sformatf("v_updated got %0d expected %0d",
                                                  v_updated, want.v));
                    if (frame_done !== want.last)
                        report_mismatch($sformatf("frame_done got %b expected %b",
                                                  frame_done, want.last));
                end
            end
            if (sample_valid && !sample_stall)
            begin
                wd  = size_used(width_reg, DEF_MAX_WIDTH);
                ht  = size_used(height_reg, DEF_MAX_HEIGHT);
                col = (col_pos >= wd) ? wd - 1 : col_pos;
                row = (row_pos >= ht) ? ht - 1 : row_pos;
                fresh[0] = u_sample;
                fresh[1] = v_sample;
                for (int lane = 0; lane < 2; lane++)
                begin
                    top = line_mem[lane][col];
                    mid = line_mem[lane][DEF_MAX_WIDTH + col];
                    for (int k = 0; k < 3; k++)
                    begin
                        grid_window[lane][k][0] = grid_window[lane][k][1];
                        grid_window[lane][k][1] = grid_window[lane][k][2];
                    end
                    grid_window[lane][0][2] = top;
                    grid_window[lane][1][2] = mid;
                    grid_window[lane][2][2] = fresh[lane];
                    line_mem[lane][col] = mid;
                    line_mem[lane][DEF_MAX_WIDTH + col] = fresh[lane];
                end
                if (row >= 2 && col >= 2)
                begin
                    res.u = diffuse(grid_window[0][1][1], grid_window[0][1][2],
                                    grid_window[0][1][0], grid_window[0][0][1],
                                    grid_window[0][2][1]);
                    res.v = diffuse(grid_window[1][1][1], grid_window[1][1][2],
                                    grid_window[1][1][0], grid_window[1][0][1],
                                    grid_window[1][2][1]);
                    res.last = (row == ht - 1) && (col == wd - 1);
                    expected_points.push_back(res);
                end
                if (col + 1 >= wd)
                begin
                    col_pos = 0;
                    row_pos = (row + 1 >= ht) ? 0 : row + 1;
                end
                else
                begin
                    col_pos = col + 1;
                    row_pos = row;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("diffusion_stencil_2d_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        int  sent_items;
        int  n;
        int  fw;
        int  fh;
        sent_items = 0;
        for (int lane = 0; lane < 2; lane++)
        begin
            for (int i = 0; i < LINE_DEPTH; i++)
                line_mem[lane][i] = '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    grid_window[lane][r][c] = '0;
        end
        send_idle_pct = 21;
        recv_idle_pct = 55;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset sizes and gains: two full rows of 251 and the start of a third.
        queue_frame_items(RESET_ITEMS, 1);
        sent_items += RESET_ITEMS;
        wait_idle();

        send_idle_pct = 55;
        recv_idle_pct = 21;

        // Sizes below the minimum clamp to 3x3; upper data bits are ignored.
        write_reg(REG_GRID_WIDTH, 16'hFE00);
        write_reg(REG_GRID_HEIGHT, 16'h0002);
        queue_frame_items(9, 1);
        sent_items += 9;
        wait_idle();

        // Largest gains against extreme samples drive both lanes into saturation.
        write_reg(REG_GAIN_X, 16'hFFFF);
        write_reg(REG_GAIN_Y, 16'hFFFF);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                queue_point(SAMPLE_MIN, SAMPLE_MAX);
            else
                queue_point(SAMPLE_MAX, SAMPLE_MIN);
        end
        sent_items += 9;
        wait_idle();

        write_reg(REG_GAIN_X, 16'd32768);
        write_reg(REG_GAIN_Y, 16'd0);
        queue_frame_items(9, 2);
        sent_items += 9;
        wait_idle();

        while (sent_items < ITEM_COUNT - WIDE_ITEMS)
        begin
            wait_idle();
            // Without a size write the frame carries on where it stopped.
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(REG_GRID_WIDTH, pick_size_data());
                write_reg(REG_GRID_HEIGHT, pick_size_data());
            end
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_GAIN_X, pick_gain());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_GAIN_Y, pick_gain());
            fw = size_used(width_reg, DEF_MAX_WIDTH);
            fh = size_used(height_reg, DEF_MAX_HEIGHT);
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, fw * fh - 1);
            else
                n = $urandom_range(1, 3) * fw * fh;
            if (n > ITEM_COUNT - WIDE_ITEMS - sent_items)
                n = ITEM_COUNT - WIDE_ITEMS - sent_items;
            queue_frame_items(n, $urandom_range(0, 2));
            sent_items += n;
        end

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Width above the maximum clamps to the full line store.
        write_reg(REG_GRID_WIDTH, 16'd511);
        write_reg(REG_GRID_HEIGHT, 16'd3);
        queue_frame_items(WIDE_ITEMS, $urandom_range(0, 2));
        sent_items += WIDE_ITEMS;

        wait_idle();
        if (error_count == 0)
            $display("diffusion_stencil_2d_core regression: pass");
        else
            $display("diffusion_stencil_2d_core regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/dst2d_pkg.sv
rtl/dst2d_seq.sv
rtl/dst2d_lane.sv
rtl/dst2d_merge.sv
rtl/diffusion_stencil_2d_core.sv
tb/diffusion_stencil_2d_core_tb.sv
